// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the reset expression is low.
`define PBWC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pbwc assertion failed");

// Next-cycle implication, disabled while the reset expression is low.
`define PBWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pbwc assertion failed");

// Next-cycle implication that is also checked while reset is active.
`define PBWC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pbwc assertion failed");

`endif

// ===== hdl/pbwc_pkg.sv =====
// Shared constants and types of the pixel bit window checker.
`timescale 1ns / 1ps
`default_nettype none
package pbwc_pkg;

    localparam int MAX_DIM         = 4096;
    localparam int COORD_W         = $clog2(MAX_DIM);
    localparam int HEIGHT_W        = COORD_W + 1;
    localparam int CH_W            = 8;
    localparam int PIX_W           = 3 * CH_W;
    localparam int TAIL_W          = 3;
    localparam int FILL_W          = 2;
    localparam int MAX_REPORTS     = 8;
    localparam int RCNT_W          = $clog2(MAX_REPORTS);
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [FILL_W-1:0]   FILL_FULL    = FILL_W'(TAIL_W);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1);

    // One pixel that produced at least one window match, with its predecessor.
    typedef struct packed {
        logic [PIX_W-1:0]   match_mask;
        logic [PIX_W-1:0]   pix;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   prev_pix;
        logic [COORD_W-1:0] prev_col;
        logic [COORD_W-1:0] prev_row;
    } t_job;

    typedef struct packed {
        logic [COORD_W-1:0] hit_col;
        logic [COORD_W-1:0] hit_row_from_bottom;
        logic [CH_W-1:0]    new_red;
        logic [CH_W-1:0]    new_green;
        logic [CH_W-1:0]    new_blue;
        logic               last_of_run;
    } t_rpt;

endpackage
`default_nettype wire

// ===== hdl/pbwc_if.sv =====
// Channel interfaces of the pixel bit window checker: pixels, reports, configuration.
`timescale 1ns / 1ps
`default_nettype none
interface pbwc_pix_if;
    import pbwc_pkg::*;
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               start_of_image;

    modport source (output valid, red, green, blue, col, row, start_of_image, input ready);
    modport sink   (input valid, red, green, blue, col, row, start_of_image, output ready);
endinterface

interface pbwc_rpt_if;
    import pbwc_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] hit_col;
    logic [COORD_W-1:0] hit_row_from_bottom;
    logic [CH_W-1:0]    new_red;
    logic [CH_W-1:0]    new_green;
    logic [CH_W-1:0]    new_blue;
    logic               last_of_run;

    modport source (output valid, hit_col, hit_row_from_bottom, new_red, new_green,
                    new_blue, last_of_run, input ready);
    modport sink   (input valid, hit_col, hit_row_from_bottom, new_red, new_green,
                    new_blue, last_of_run, output ready);
endinterface

interface pbwc_cfg_if;
    import pbwc_pkg::*;
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pbwc_front.sv =====
// Front end: serializes each pixel into the bit window and marks every match position.
`timescale 1ns / 1ps
`default_nettype none
module pbwc_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_accept,
    input  wire  [pbwc_pkg::CH_W-1:0]    i_red,
    input  wire  [pbwc_pkg::CH_W-1:0]    i_green,
    input  wire  [pbwc_pkg::CH_W-1:0]    i_blue,
    input  wire  [pbwc_pkg::COORD_W-1:0] i_col,
    input  wire  [pbwc_pkg::COORD_W-1:0] i_row,
    input  wire                          i_start_of_image,
    output logic                         o_push,
    output pbwc_pkg::t_job               o_job
);
    import pbwc_pkg::*;

    localparam int STREAM_W = TAIL_W + PIX_W;

    logic [TAIL_W-1:0]   r_tail;
    logic [FILL_W-1:0]   r_fill;
    logic [PIX_W-1:0]    r_prev_pix;
    logic [COORD_W-1:0]  r_prev_col;
    logic [COORD_W-1:0]  r_prev_row;

    logic [TAIL_W-1:0]   tail0;
    logic [FILL_W-1:0]   fill0;
    logic [PIX_W-1:0]    pix;
    logic [STREAM_W-1:0] stream;
    logic [PIX_W-1:0]    mask;

    assign pix = {i_red, i_green, i_blue};

    // Oldest stream bit sits at the top of the vector. The window ending at
    // pixel bit k spans stream bits STREAM_W-1-k down to PIX_W-1-k.
    always_comb begin
        tail0  = i_start_of_image ? '0 : r_tail;
        fill0  = i_start_of_image ? '0 : r_fill;
        stream = {tail0, pix};
        for (int k = 0; k < PIX_W; k++) begin
            mask[k] = (stream[STREAM_W-1-k] == stream[STREAM_W-2-k]) &&
                      (stream[STREAM_W-4-k] == stream[STREAM_W-2-k]) &&
                      (stream[STREAM_W-3-k] != stream[STREAM_W-2-k]) &&
                      ((6'(k) + 6'(fill0)) >= 6'(TAIL_W));
        end
    end

    always_comb begin
        o_job.match_mask = mask;
        o_job.pix        = pix;
        o_job.col        = i_col;
        o_job.row        = i_row;
        o_job.prev_pix   = r_prev_pix;
        o_job.prev_col   = r_prev_col;
        o_job.prev_row   = r_prev_row;
        o_push           = i_accept && (|mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail     <= '0;
            r_fill     <= '0;
            r_prev_pix <= '0;
            r_prev_col <= '0;
            r_prev_row <= '0;
        end else if (i_accept) begin
            // A whole pixel always fills the window.
            r_tail     <= pix[TAIL_W-1:0];
            r_fill     <= FILL_FULL;
            r_prev_pix <= pix;
            r_prev_col <= i_col;
            r_prev_row <= i_row;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/pbwc_fifo.sv =====
// Short job queue between the front end and the report engine.
`timescale 1ns / 1ps
`default_nettype none
module pbwc_fifo #(
    parameter int DEPTH = pbwc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  wire pbwc_pkg::t_job i_data,
    input  wire             i_pop,
    output logic            o_empty,
    output logic            o_full,
    output pbwc_pkg::t_job  o_head
);
    import pbwc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_slot [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;

    logic            do_push;
    logic            do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_head  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/pbwc_back.sv =====
// Report engine: walks the queue head match mask; one report per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module pbwc_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_empty,
    input  wire pbwc_pkg::t_job          i_head,
    input  wire  [pbwc_pkg::COORD_W-1:0] i_height,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire                          i_ready,
    output pbwc_pkg::t_rpt               o_rpt
);
    import pbwc_pkg::*;

    logic [PIX_W-1:0]  r_done;
    logic [RCNT_W-1:0] r_cnt;
    logic              r_valid;
    t_rpt              r_rpt;

    logic [PIX_W-1:0]   remain;
    logic [PIX_W-1:0]   lowest;
    logic [PIX_W-1:0]   flip;
    logic [PIX_W-1:0]   val;
    logic [COORD_W-1:0] hrow;
    logic               last;
    logic               emit;
    t_rpt               rpt;

    always_comb begin
        remain = i_head.match_mask & ~r_done;
        lowest = remain & (~remain + PIX_W'(1));
        // Match at pixel bit k flips the bit just before it, which sits at
        // position PIX_W-k of the pixel word; k of zero points into the
        // previous pixel's last bit.
        flip    = '0;
        for (int j = 1; j < PIX_W; j++) begin
            flip[PIX_W-j] = lowest[j];
        end
        if (lowest[0]) begin
            val         = i_head.prev_pix ^ PIX_W'(1);
            hrow        = i_head.prev_row;
            rpt.hit_col = i_head.prev_col;
        end else begin
            val         = i_head.pix ^ flip;
            hrow        = i_head.row;
            rpt.hit_col = i_head.col;
        end
        last = ((remain & ~lowest) == '0) || (r_cnt == RCNT_W'(MAX_REPORTS - 1));
        rpt.hit_row_from_bottom = i_height - COORD_W'(1) - hrow;
        rpt.new_red             = val[3*CH_W-1:2*CH_W];
        rpt.new_green           = val[2*CH_W-1:CH_W];
        rpt.new_blue            = val[CH_W-1:0];
        rpt.last_of_run         = last;
        emit                    = !i_empty && (!r_valid || i_ready);
    end

    assign o_pop   = emit && last;
    assign o_valid = r_valid;
    assign o_rpt   = r_rpt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
                if (last) begin
                    r_done <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= r_done | lowest;
                    r_cnt  <= r_cnt + RCNT_W'(1);
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_rpt <= rpt;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/pixel_bit_window_checker.sv =====
// Pixel bit window checker: RGB pixels enter one per clock and are serialized
// red, green, blue, MSB first into one bit stream. Each pixel that completes
// a 0010 or 1101 window is queued with its match positions; the report engine
// emits one report per clock from the queue head unless stalled, at most eight
// per pixel, the last flagged by last_of_run. A pixel with matches occupies the
// report engine until its last report is emitted. The job queue holds
// QUEUE_DEPTH matching pixels and the pixel channel stalls only while it is
// full. The image height register is written over the configuration channel,
// which is always ready, and should be changed only while no report is pending.
`timescale 1ns / 1ps
`default_nettype none
module pixel_bit_window_checker #(
    parameter int QUEUE_DEPTH = pbwc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pbwc_pix_if.sink    i_pix,
    pbwc_rpt_if.source  o_rpt,
    pbwc_cfg_if.sink    i_cfg
);
    import pbwc_pkg::*;

    logic [HEIGHT_W-1:0] r_height;

    logic  pix_accept;
    logic  push;
    logic  pop;
    logic  empty;
    logic  full;
    logic  rpt_valid;
    t_job  job;
    t_job  head;
    t_rpt  rpt;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !full;
    assign pix_accept  = i_pix.valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            r_height <= i_cfg.data;
        end
    end

    pbwc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (pix_accept),
        .i_red            (i_pix.red),
        .i_green          (i_pix.green),
        .i_blue           (i_pix.blue),
        .i_col            (i_pix.col),
        .i_row            (i_pix.row),
        .i_start_of_image (i_pix.start_of_image),
        .o_push           (push),
        .o_job            (job)
    );

    pbwc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job),
        .i_pop   (pop),
        .o_empty (empty),
        .o_full  (full),
        .o_head  (head)
    );

    pbwc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .i_height (r_height[COORD_W-1:0]),
        .o_pop    (pop),
        .o_valid  (rpt_valid),
        .i_ready  (o_rpt.ready),
        .o_rpt    (rpt)
    );

    assign o_rpt.valid               = rpt_valid;
    assign o_rpt.hit_col             = rpt.hit_col;
    assign o_rpt.hit_row_from_bottom = rpt.hit_row_from_bottom;
    assign o_rpt.new_red             = rpt.new_red;
    assign o_rpt.new_green           = rpt.new_green;
    assign o_rpt.new_blue            = rpt.new_blue;
    assign o_rpt.last_of_run         = rpt.last_of_run;
endmodule
`default_nettype wire

// ===== hdl/pbwc_checker.sv =====
// Port-level assertions for the pixel bit window checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pbwc_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_pix_ready,
    input wire                          i_rpt_valid,
    input wire                          i_rpt_ready,
    input wire  [pbwc_pkg::COORD_W-1:0] i_hit_col,
    input wire  [pbwc_pkg::COORD_W-1:0] i_hit_row,
    input wire  [pbwc_pkg::CH_W-1:0]    i_new_red,
    input wire  [pbwc_pkg::CH_W-1:0]    i_new_green,
    input wire  [pbwc_pkg::CH_W-1:0]    i_new_blue,
    input wire                          i_last_of_run
);
    import pbwc_pkg::*;

    logic [2*COORD_W+3*CH_W:0] rpt_bits;
    logic                      rpt_stall;

    assign rpt_bits  = {i_hit_col, i_hit_row, i_new_red, i_new_green, i_new_blue,
                        i_last_of_run};
    assign rpt_stall = i_rpt_valid && !i_rpt_ready;

    // Reset empties the output register.
    `PBWC_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !i_rpt_valid)

    // A stalled report keeps its contents until the transaction completes.
    `PBWC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, rpt_stall, i_rpt_valid && $stable(rpt_bits))

    // A full job queue always has a report on offer in the following cycle.
    `PBWC_ASSERT_NEXT(a_backlog_drains, i_clk, i_rst_n, !i_pix_ready, i_rpt_valid)

endmodule

bind pixel_bit_window_checker pbwc_checker u_pbwc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_pix_ready   (i_pix.ready),
    .i_rpt_valid   (o_rpt.valid),
    .i_rpt_ready   (o_rpt.ready),
    .i_hit_col     (o_rpt.hit_col),
    .i_hit_row     (o_rpt.hit_row_from_bottom),
    .i_new_red     (o_rpt.new_red),
    .i_new_green   (o_rpt.new_green),
    .i_new_blue    (o_rpt.new_blue),
    .i_last_of_run (o_rpt.last_of_run)
);
`default_nettype wire
